/* rtl/rsq_pkg.sv */
// Shared types, constants and helpers for the reciprocal square root unit.
// Used by rsq_fmul, rsq_fadd and fast_inverse_square_root_unit; no dependencies.
package rsq_pkg;

	localparam logic [31:0] GUESS_MAGIC = 32'h5f3759df;
	localparam logic [31:0] F32_HALF    = 32'h3f000000;
	localparam logic [31:0] F32_ONE_P5  = 32'h3fc00000;
	localparam logic [31:0] F32_QNAN    = 32'h7fc00000;
	localparam logic [7:0]  EXP_MAX     = 8'hff;

	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
	} rsq_kind_t;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

endpackage

/* rtl/fast_inverse_square_root_unit.sv */
// Fast reciprocal square root: magic-constant guess plus one Newton step.
// Depends on rsq_pkg, rsq_fmul and rsq_fadd.
//
// Usage:
//   Drive operand_bits with a binary32 pattern and raise start for one cycle
//   per beat; a beat is taken at each rising edge where start is high and busy
//   is low. busy never rises, so a beat may enter on every cycle.
//   The result appears on result_bits with done high for exactly one cycle,
//   in order of entry.
//   Throughput is one beat per cycle: the datapath is a chain of three-stage
//   multiply and add units (half, half*y, *y, 1.5-t, y*s) behind an input
//   register, with the guess carried alongside in a delay line.
//   The receiver has no way to stall; every result must be taken when done is
//   high. Reset clears all valid bits, dropping beats in flight.
//   Any NaN result is delivered as 0x7FC00000.
module fast_inverse_square_root_unit import rsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] operand_bits,
	output logic        done,
	output logic [31:0] result_bits
);

	localparam int YDLY = 12;

	logic        v_s0;
	logic [31:0] x_s0, y_s0;
	logic [31:0] y_dly_s [YDLY];

	logic        half_v, t1_v, t2_v, s_v, r_v;
	logic [31:0] half_w, t1_w, t2_w, s_w, r_w;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s0 <= operand_bits;
		y_s0 <= GUESS_MAGIC - {1'b0, operand_bits[31:1]};
		y_dly_s[0] <= y_s0;
		for (int i = 1; i < YDLY; i++) begin
			y_dly_s[i] <= y_dly_s[i-1];
		end
	end

	rsq_fmul u_half (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s0),
		.a(x_s0), .b(F32_HALF), .out_valid(half_v), .p(half_w)
	);

	rsq_fmul u_t1 (
		.clk(clk), .arst_n(arst_n), .in_valid(half_v),
		.a(half_w), .b(y_dly_s[2]), .out_valid(t1_v), .p(t1_w)
	);

	rsq_fmul u_t2 (
		.clk(clk), .arst_n(arst_n), .in_valid(t1_v),
		.a(t1_w), .b(y_dly_s[5]), .out_valid(t2_v), .p(t2_w)
	);

	rsq_fadd u_sub (
		.clk(clk), .arst_n(arst_n), .in_valid(t2_v),
		.a(F32_ONE_P5), .b({~t2_w[31], t2_w[30:0]}), .out_valid(s_v), .s(s_w)
	);

	rsq_fmul u_r (
		.clk(clk), .arst_n(arst_n), .in_valid(s_v),
		.a(y_dly_s[11]), .b(s_w), .out_valid(r_v), .p(r_w)
	);

	assign done        = r_v;
	assign result_bits = r_w;

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 16))
		else $error("result without a beat 16 cycles earlier");

	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##16 done)
		else $error("accepted beat produced no result");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_bits[30:23] == EXP_MAX && result_bits[22:0] != 23'd0)
		|-> result_bits == F32_QNAN)
		else $error("non-canonical NaN on result");

endmodule

/* rtl/rsq_fmul.sv */
// Three-stage binary32 multiplier, round to nearest even, subnormals kept.
// Depends on rsq_pkg; any NaN result is the canonical quiet NaN.
module rsq_fmul import rsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] p
);

	logic [7:0]  ea, eb, eae, ebe;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	rsq_kind_t   kind_c;

	logic               v_s1, sgn_s1;
	logic [47:0]        prod_s1;
	logic signed [10:0] exp_s1;
	rsq_kind_t          kind_s1;

	logic               v_s2, sgn_s2, stk_s2, ovf_s2;
	logic [47:0]        norm_s2;
	logic [7:0]         expf_s2;
	rsq_kind_t          kind_s2;

	logic               v_s3;
	logic [31:0]        p_s3;

	logic [5:0]         lz;
	logic signed [10:0] r;
	logic [6:0]         rsh;
	logic [95:0]        wide;
	logic [47:0]        norm_c;
	logic [7:0]         expf_c;
	logic               stk_c, ovf_c;

	logic               inc;
	logic [30:0]        packed_c;
	logic [31:0]        p_c;

	assign ea     = a[30:23];
	assign eb     = b[30:23];
	assign eae    = (ea == 8'd0) ? 8'd1 : ea;
	assign ebe    = (eb == 8'd0) ? 8'd1 : eb;
	assign a_nan  = (ea == EXP_MAX) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == EXP_MAX) && (b[22:0] != 23'd0);
	assign a_inf  = (ea == EXP_MAX) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == EXP_MAX) && (b[22:0] == 23'd0);
	assign a_zero = (a[30:0] == 31'd0);
	assign b_zero = (b[30:0] == 31'd0);

	always_comb begin
		kind_c.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		kind_c.inf  = (a_inf | b_inf) & ~kind_c.nan;
		kind_c.zero = (a_zero | b_zero) & ~kind_c.nan & ~kind_c.inf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1  <= a[31] ^ b[31];
		prod_s1 <= {24'd0, ea != 8'd0, a[22:0]} * {24'd0, eb != 8'd0, b[22:0]};
		exp_s1  <= $signed(11'(eae) + 11'(ebe) - 11'd127);
		kind_s1 <= kind_c;
	end

	always_comb begin
		lz     = lzc48(prod_s1);
		r      = exp_s1 + 11'sd1 - $signed({5'd0, lz});
		rsh    = 7'(-exp_s1);
		wide   = {prod_s1, 48'd0} >> rsh;
		stk_c  = 1'b0;
		ovf_c  = 1'b0;
		expf_c = 8'd0;
		if (r >= 11'sd1) begin
			norm_c = prod_s1 << lz;
			expf_c = r[7:0];
			ovf_c  = (r >= 11'sd255);
		end else if (exp_s1 >= 11'sd0) begin
			norm_c = prod_s1 << exp_s1[5:0];
		end else begin
			norm_c = wide[95:48];
			stk_c  = |wide[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s2  <= sgn_s1;
		norm_s2 <= norm_c;
		stk_s2  <= stk_c;
		expf_s2 <= expf_c;
		ovf_s2  <= ovf_c;
		kind_s2 <= kind_s1;
	end

	always_comb begin
		inc      = norm_s2[23] & ((|norm_s2[22:0]) | stk_s2 | norm_s2[24]);
		packed_c = {expf_s2, norm_s2[46:24]} + 31'(inc);
		if (kind_s2.nan) begin
			p_c = F32_QNAN;
		end else if (kind_s2.inf || ovf_s2) begin
			p_c = {sgn_s2, EXP_MAX, 23'd0};
		end else if (kind_s2.zero) begin
			p_c = {sgn_s2, 31'd0};
		end else begin
			p_c = {sgn_s2, packed_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s3 <= p_c;
	end

	assign out_valid = v_s3;
	assign p         = p_s3;

endmodule

/* rtl/rsq_fadd.sv */
// Three-stage binary32 adder, round to nearest even, subnormals kept.
// Depends on rsq_pkg; any NaN result is the canonical quiet NaN.
module rsq_fadd import rsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] s
);

	logic        swap;
	logic [31:0] big, sml;
	logic [7:0]  eb_raw, es_raw, ebe, ese, d;
	logic        a_nan, b_nan, a_inf, b_inf;
	logic [53:0] wide;
	rsq_kind_t   kind_c;

	logic        v_s1, sgn_s1, sub_s1, zsgn_s1, isgn_s1;
	logic [26:0] al_s1, bs_s1;
	logic [7:0]  exp_s1;
	rsq_kind_t   kind_s1;

	logic [27:0] sum;
	logic [5:0]  lz;
	logic [7:0]  maxsh, sh;
	logic [26:0] norm_c;
	logic [8:0]  e_c;

	logic        v_s2, sgn_s2, zsgn_s2, isgn_s2, zero_s2;
	logic [26:0] norm_s2;
	logic [8:0]  e_s2;
	rsq_kind_t   kind_s2;

	logic [7:0]  expf;
	logic        inc;
	logic [30:0] packed_c;
	logic [31:0] s_c;

	logic        v_s3;
	logic [31:0] s_s3;

	assign a_nan  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
	assign b_nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
	assign a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
	assign b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
	assign swap   = b[30:0] > a[30:0];
	assign big    = swap ? b : a;
	assign sml    = swap ? a : b;
	assign eb_raw = big[30:23];
	assign es_raw = sml[30:23];
	assign ebe    = (eb_raw == 8'd0) ? 8'd1 : eb_raw;
	assign ese    = (es_raw == 8'd0) ? 8'd1 : es_raw;
	assign d      = ebe - ese;
	assign wide   = {es_raw != 8'd0, sml[22:0], 3'd0, 27'd0} >> d;

	always_comb begin
		kind_c.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
		kind_c.inf  = (a_inf | b_inf) & ~kind_c.nan;
		kind_c.zero = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1  <= big[31];
		sub_s1  <= a[31] ^ b[31];
		zsgn_s1 <= a[31] & b[31];
		isgn_s1 <= a_inf ? a[31] : b[31];
		al_s1   <= {eb_raw != 8'd0, big[22:0], 3'd0};
		bs_s1   <= wide[53:27] | {26'd0, |wide[26:0]};
		exp_s1  <= ebe;
		kind_s1 <= kind_c;
	end

	always_comb begin
		sum   = sub_s1 ? ({1'b0, al_s1} - {1'b0, bs_s1}) : ({1'b0, al_s1} + {1'b0, bs_s1});
		lz    = lzc48({sum[26:0], 21'd0});
		maxsh = exp_s1 - 8'd1;
		sh    = (8'(lz) < maxsh) ? 8'(lz) : maxsh;
		if (sum[27]) begin
			norm_c = {sum[27:2], sum[1] | sum[0]};
			e_c    = 9'(exp_s1) + 9'd1;
		end else begin
			norm_c = sum[26:0] << sh;
			e_c    = 9'(exp_s1) - 9'(sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s2  <= sgn_s1;
		zsgn_s2 <= zsgn_s1;
		isgn_s2 <= isgn_s1;
		zero_s2 <= (sum == 28'd0);
		norm_s2 <= norm_c;
		e_s2    <= e_c;
		kind_s2 <= kind_s1;
	end

	always_comb begin
		expf     = norm_s2[26] ? e_s2[7:0] : 8'd0;
		inc      = norm_s2[2] & (norm_s2[1] | norm_s2[0] | norm_s2[3]);
		packed_c = {expf, norm_s2[25:3]} + 31'(inc);
		if (kind_s2.nan) begin
			s_c = F32_QNAN;
		end else if (kind_s2.inf) begin
			s_c = {isgn_s2, EXP_MAX, 23'd0};
		end else if (e_s2 >= 9'd255) begin
			s_c = {sgn_s2, EXP_MAX, 23'd0};
		end else if (zero_s2) begin
			s_c = {zsgn_s2, 31'd0};
		end else begin
			s_c = {sgn_s2, packed_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		s_s3 <= s_c;
	end

	assign out_valid = v_s3;
	assign s         = s_s3;

endmodule

/* sim/fast_inverse_square_root_unit_tb.sv */
// Self-checking testbench for fast_inverse_square_root_unit: binary32 reciprocal square root.
// Holds a bit-exact binary32 predictor for the guess and Newton step; depends on the RTL only.
`timescale 1ns / 100ps

module fast_inverse_square_root_unit_tb;

	localparam logic [31:0] MAGIC     = 32'h5f3759df;
	localparam logic [31:0] F_HALF    = 32'h3f000000;
	localparam logic [31:0] F_ONE_P5  = 32'h3fc00000;
	localparam logic [31:0] F_QNAN    = 32'h7fc00000;
	localparam int          WATCHDOG  = 2000;
	localparam int          LATENCY   = 16;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] operand_bits;
	logic        done;
	logic [31:0] result_bits;

	logic [31:0] rsqrt_expected[$];
	int          errors;
	int          idle_cycles;

	fast_inverse_square_root_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operand_bits (operand_bits),
		.done         (done),
		.result_bits  (result_bits)
	);

	always #5 clk = ~clk;

	function automatic logic is_nan(input logic [31:0] a);
		return a[30:23] == 8'hff && a[22:0] != 0;
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return a[30:23] == 8'hff && a[22:0] == 0;
	endfunction

	function automatic logic is_zero(input logic [31:0] a);
		return a[30:0] == 0;
	endfunction

	function automatic logic [23:0] sig_of(input logic [31:0] a);
		return (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
	endfunction

	function automatic int exp_of(input logic [31:0] a);
		return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
	endfunction

	// round sign * mag * 2^scale to binary32, nearest even; mag is nonzero
	function automatic logic [31:0] round_f32(input logic sgn, input logic [63:0] mag,
			input int scale);
		int          msb;
		int          lsb_exp;
		int          sh;
		int          be;
		logic [127:0] wide;
		logic [63:0] q;
		logic        g;
		logic        st;
		msb = 0;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) msb = i;
		end
		lsb_exp = msb + scale - 23;
		if (lsb_exp < -149) lsb_exp = -149;
		sh = lsb_exp - scale;
		if (sh <= 0) begin
			q = mag << (-sh);
			g = 1'b0;
			st = 1'b0;
		end else if (sh > 64) begin
			q = 0;
			g = 1'b0;
			st = 1'b1;
		end else begin
			wide = {mag, 64'b0} >> sh;
			q = wide[127:64];
			g = wide[63];
			st = |wide[62:0];
		end
		if (g && (st || q[0])) q = q + 1;
		if (q == 64'd1 << 24) begin
			q = q >> 1;
			lsb_exp++;
		end
		if (q < 64'd1 << 23) return {sgn, 8'h00, q[22:0]};
		be = lsb_exp + 150;
		if (be >= 255) return {sgn, 8'hff, 23'b0};
		return {sgn, be[7:0], q[22:0]};
	endfunction

	function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
		logic sgn;
		sgn = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b)) return F_QNAN;
		if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return F_QNAN;
		if (is_inf(a) || is_inf(b)) return {sgn, 8'hff, 23'b0};
		if (is_zero(a) || is_zero(b)) return {sgn, 31'b0};
		return round_f32(sgn, 64'(sig_of(a)) * 64'(sig_of(b)), exp_of(a) + exp_of(b));
	endfunction

	function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b_in);
		logic [31:0] b;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [63:0] big;
		logic [63:0] lil;
		logic [63:0] mag;
		logic        sgn;
		int          d;
		b = {~b_in[31], b_in[30:0]};
		if (is_nan(a) || is_nan(b)) return F_QNAN;
		if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : F_QNAN;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'b0};
		if (is_zero(a)) return b;
		if (is_zero(b)) return a;
		if (exp_of(a) >= exp_of(b)) begin
			hi = a;
			lo = b;
		end else begin
			hi = b;
			lo = a;
		end
		d = exp_of(hi) - exp_of(lo);
		big = 64'(sig_of(hi)) << 39;
		lil = 64'(sig_of(lo)) << 39;
		if (d >= 64) begin
			lil = 64'd1;
		end else if (d > 0) begin
			lil = (lil >> d) | 64'(((lil << (64 - d)) != 0));
		end
		if (hi[31] == lo[31]) begin
			mag = big + lil;
			sgn = hi[31];
		end else if (big >= lil) begin
			mag = big - lil;
			sgn = hi[31];
		end else begin
			mag = lil - big;
			sgn = lo[31];
		end
		if (mag == 0) return 32'h0;
		return round_f32(sgn, mag, exp_of(hi) - 39);
	endfunction

	function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
		logic [31:0] half;
		logic [31:0] guess;
		logic [31:0] t;
		logic [31:0] r;
		half = f32_mul(x, F_HALF);
		guess = MAGIC - (x >> 1);
		t = f32_mul(half, guess);
		t = f32_mul(t, guess);
		r = f32_mul(guess, f32_sub(F_ONE_P5, t));
		return is_nan(r) ? F_QNAN : r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsqrt_expected.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result_bits);
				errors++;
			end else begin
				if (result_bits !== rsqrt_expected[0]) begin
					$display("%0t: result_bits expected %h actual %h", $time,
						rsqrt_expected[0], result_bits);
					errors++;
				end
				void'(rsqrt_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("fast_inverse_square_root_unit_tb NOT OK");
				$finish;
			end
		end
	end

	int gap_mode;

	task automatic send_beat(input logic [31:0] x);
		int gap;
		if (gap_mode == 0) gap = 0;
		else if ($urandom_range(0, 19) == 0) gap = $urandom_range(5, 30);
		else gap = $urandom_range(0, 2);
		if (gap > 0) begin
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		operand_bits <= x;
		do @(posedge clk); while (busy);
		rsqrt_expected.push_back(predict_rsqrt(x));
	endtask

	task automatic wait_drained();
		@(negedge clk) start <= 1'b0;
		while (rsqrt_expected.size() != 0) @(posedge clk);
	endtask

	task automatic test_special_operands();
		logic [31:0] vals[$];
		vals = {32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00001,
			32'h7f800001, 32'hffffffff, 32'h00000001, 32'h807fffff, 32'h007fffff,
			32'h00800000, 32'h3f800000, 32'h40800000, 32'h7f7fffff, 32'h3e800000,
			32'hbf800000, 32'h5f3759df, 32'hbe000000, 32'h7fffffff, 32'h00000002};
		gap_mode = 0;
		foreach (vals[i]) send_beat(vals[i]);
	endtask

	task automatic test_random_operands(input int n);
		logic [31:0] x;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) gap_mode = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0, 1, 2: x = $urandom;
				3: x = {1'($urandom), 8'h00, 23'($urandom)};
				4: x = {1'($urandom), 8'hff, ($urandom_range(0, 1) ? 23'($urandom) : 23'h0)};
				default: x = {1'b0, 8'($urandom_range(90, 165)), 23'($urandom)};
			endcase
			send_beat(x);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operand_bits = 32'h0;
		errors = 0;
		gap_mode = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_special_operands();
		wait_drained();
		test_random_operands(450);
		wait_drained();
		test_random_operands(450);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("fast_inverse_square_root_unit_tb OK");
		end else begin
			$display("fast_inverse_square_root_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
